### rtl/prrts_pkg.sv
// ----------------------------------------------------------------------------
// prrts_pkg: shared types and codes of the priority round-robin task scheduler
// Holds the request codes, task status codes, result codes, sequencer states
// and the write command that the sequencer hands to the slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prrts_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int PRIO_BITS_DEF  = 8;

  // Fixed widths of the request and result fields.
  localparam int REQ_W        = 3;
  localparam int SLOT_FIELD_W = 4;
  localparam int PRIO_FIELD_W = 8;
  localparam int CODE_W       = 2;

  typedef enum logic [1:0] {
    ST_RUNNING   = 2'd0,
    ST_SUSPENDED = 2'd1,
    ST_UNINTR    = 2'd2
  } task_status_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD      = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_SET_RUN  = 3'd2,
    REQ_SUSPEND  = 3'd3,
    REQ_UNINTR   = 3'd4,
    REQ_CHG_PRIO = 3'd5,
    REQ_SCHEDULE = 3'd6
  } req_t;

  localparam logic [CODE_W-1:0] CODE_OK      = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ILLEGAL = 2'd1;
  localparam logic [CODE_W-1:0] CODE_NONE    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MODIFY,
    S_TOP,
    S_PICK,
    S_FINISH
  } seq_state_t;

  // Write command for one slot of the table.
  typedef struct packed {
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } tbl_cmd_t;

endpackage

`default_nettype wire

### rtl/priority_round_robin_task_scheduler.sv
// An edit request reads its slot, applies the edit and then scans the table once.
// A schedule request makes up to two passes over the table (find the top level, then pick).
// Throughput: one request at a time; the table scan reads one slot per cycle through the
// single read port of the slot memory.
// Reset clears all valid bits at once, so every slot is empty and no task is chosen.
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler: fixed-priority round-robin scheduler
// Keeps a table of task slots, applies add, remove, status and priority edits,
// and on request picks the next task at the highest ready priority level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module priority_round_robin_task_scheduler #(
  parameter int TASK_SLOTS = prrts_pkg::TASK_SLOTS_DEF,
  parameter int PRIO_BITS  = prrts_pkg::PRIO_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [prrts_pkg::REQ_W-1:0]         req_type,
  input  logic [prrts_pkg::SLOT_FIELD_W-1:0]  task_slot,
  input  logic [prrts_pkg::PRIO_FIELD_W-1:0]  task_prio,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [prrts_pkg::SLOT_FIELD_W-1:0]  selected_slot,
  output logic                                selected_valid,
  output logic [prrts_pkg::PRIO_FIELD_W-1:0]  top_level,
  output logic [prrts_pkg::CODE_W-1:0]        status_code
);
  import prrts_pkg::*;

  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  // Sequencer state and the scheduling state proper.
  seq_state_t state, state_next;
  logic [SLOT_W-1:0] current_task;
  logic              started;

  // The request being worked on.
  logic [REQ_W-1:0]     req;
  logic [SLOT_W-1:0]    slot;
  logic [PRIO_BITS-1:0] prio;
  logic [CODE_W-1:0]    code;

  // Scan engine: one table read issued per cycle, its data handled in the next cycle.
  logic [CNT_W-1:0]     scan_cnt;
  logic [SLOT_W-1:0]    scan_addr;
  logic                 pend;
  logic [SLOT_W-1:0]    pend_idx;
  logic                 any_ready;
  logic [PRIO_BITS-1:0] best;
  logic                 cur_unintr;
  logic                 found;
  logic [SLOT_W-1:0]    found_idx;

  // Table interface.
  logic [SLOT_W-1:0]    rd_addr;
  tbl_cmd_t             cmd;
  task_status_t         wr_status;
  logic [PRIO_BITS-1:0] wr_prio;
  logic                 rd_valid;
  task_status_t         rd_status;
  logic [PRIO_BITS-1:0] rd_prio;

  logic              in_accept;
  logic              in_range;
  logic              is_edit;
  logic              scan_init;
  logic              scan_pick;
  logic [SLOT_W-1:0] scan_first;
  logic              scan_done;
  logic [SLOT_W-1:0] scan_addr_inc;
  logic [CODE_W-1:0] edit_code;
  logic              drop_current;
  logic              out_load;

  prrts_slot_table #(
    .TASK_SLOTS (TASK_SLOTS),
    .PRIO_BITS  (PRIO_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .cmd       (cmd),
    .wr_addr   (slot),
    .wr_status (wr_status),
    .wr_prio   (wr_prio),
    .rd_valid  (rd_valid),
    .rd_status (rd_status),
    .rd_prio   (rd_prio)
  );

  assign in_accept = in_valid && !in_stall;

  // A slot number past the end of the table is rejected; with sixteen or more
  // slots every slot number that the request field can carry is in range.
  assign in_range = 32'(task_slot) < 32'(TASK_SLOTS);
  assign is_edit  = (req_type < REQ_SCHEDULE) && in_range;

  assign scan_addr_inc = (scan_addr == LAST_SLOT) ? '0 : scan_addr + 1'b1;
  assign scan_done     = (scan_cnt == CNT_W'(TASK_SLOTS)) && !pend;

  // Sequencer: next state, table command and edit decision.
  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    rd_addr      = scan_addr;
    cmd          = '0;
    wr_status    = rd_status;
    wr_prio      = rd_prio;
    edit_code    = CODE_OK;
    drop_current = 1'b0;
    scan_init    = 1'b0;
    scan_pick    = 1'b0;
    scan_first   = '0;
    out_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (is_edit) begin
            state_next = S_READ;
          end else begin
            state_next = S_TOP;
            scan_init  = 1'b1;
          end
        end
      end
      S_READ: begin
        rd_addr    = slot;
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        state_next = S_TOP;
        scan_init  = 1'b1;
        if (req == REQ_ADD) begin
          if (rd_valid) begin
            edit_code = CODE_ILLEGAL;
          end else begin
            cmd.wr_en     = 1'b1;
            cmd.set_valid = 1'b1;
            wr_status     = ST_RUNNING;
            wr_prio       = prio;
          end
        end else if (!rd_valid) begin
          edit_code = CODE_ILLEGAL;
        end else begin
          unique case (req)
            REQ_REMOVE: begin
              cmd.clr_valid = 1'b1;
              drop_current  = started && (current_task == slot);
            end
            REQ_SET_RUN: begin
              cmd.wr_en = 1'b1;
              wr_status = ST_RUNNING;
            end
            REQ_SUSPEND: begin
              if (rd_status == ST_UNINTR) begin
                edit_code = CODE_ILLEGAL;
              end else begin
                cmd.wr_en = 1'b1;
                wr_status = ST_SUSPENDED;
              end
            end
            REQ_UNINTR: begin
              cmd.wr_en = 1'b1;
              wr_status = ST_UNINTR;
            end
            REQ_CHG_PRIO: begin
              cmd.wr_en = 1'b1;
              wr_prio   = prio;
            end
            default: begin
            end
          endcase
        end
      end
      S_TOP: begin
        if (scan_done) begin
          if ((req == REQ_SCHEDULE) && any_ready && !(started && cur_unintr)) begin
            // Round-robin pass starts after the current slot (else at 0) and ends on it.
            state_next = S_PICK;
            scan_init  = 1'b1;
            scan_pick  = 1'b1;
            if (started) begin
              scan_first = (current_task == LAST_SLOT) ? '0 : current_task + 1'b1;
            end
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_PICK: begin
        if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      current_task <= '0;
      started      <= 1'b0;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
    end else begin
      state <= state_next;
      if (drop_current) begin
        started <= 1'b0;
      end
      if ((state == S_PICK) && scan_done && found) begin
        current_task <= found_idx;
        started      <= 1'b1;
      end
      if (scan_init) begin
        pend <= 1'b0;
      end else if ((state == S_TOP) || (state == S_PICK)) begin
        pend <= (scan_cnt != CNT_W'(TASK_SLOTS));
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request, scan and result payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req  <= req_type;
      slot <= SLOT_W'(task_slot);
      prio <= PRIO_BITS'(task_prio);
      code <= ((req_type == REQ_SCHEDULE) || is_edit) ? CODE_OK : CODE_ILLEGAL;
    end
    if (state == S_MODIFY) begin
      code <= edit_code;
    end
    if ((state == S_TOP) && scan_done && (req == REQ_SCHEDULE) && !any_ready) begin
      code <= CODE_NONE;
    end
    if ((state == S_PICK) && scan_done) begin
      code <= found ? CODE_OK : CODE_NONE;
    end

    if (scan_init) begin
      scan_cnt  <= '0;
      scan_addr <= scan_first;
      found     <= 1'b0;
      if (!scan_pick) begin
        any_ready  <= 1'b0;
        best       <= '0;
        cur_unintr <= 1'b0;
      end
    end else if ((state == S_TOP) || (state == S_PICK)) begin
      if (scan_cnt != CNT_W'(TASK_SLOTS)) begin
        scan_cnt  <= scan_cnt + 1'b1;
        scan_addr <= scan_addr_inc;
        pend_idx  <= scan_addr;
      end
      if (pend && (state == S_TOP)) begin
        if (rd_valid && (rd_status != ST_SUSPENDED) && (!any_ready || (rd_prio > best))) begin
          best      <= rd_prio;
          any_ready <= 1'b1;
        end
        if (pend_idx == current_task) begin
          cur_unintr <= rd_valid && (rd_status == ST_UNINTR);
        end
      end
      if (pend && (state == S_PICK)) begin
        if (!found && rd_valid && (rd_status == ST_RUNNING) && (rd_prio == best)) begin
          found     <= 1'b1;
          found_idx <= pend_idx;
        end
      end
    end

    if (out_load) begin
      selected_slot  <= started ? SLOT_FIELD_W'(current_task) : '0;
      selected_valid <= started;
      top_level      <= PRIO_FIELD_W'(best);
      status_code    <= code;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("scheduler took a new request while busy");

  a_code_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status_code == CODE_OK || status_code == CODE_ILLEGAL ||
                   status_code == CODE_NONE))
    else $error("result carries an unknown status code");

  a_no_task_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !selected_valid |-> selected_slot == '0)
    else $error("slot reported while no task is chosen");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOP || state == S_PICK) |-> scan_cnt <= CNT_W'(TASK_SLOTS))
    else $error("table scan ran past the last slot");
`endif

endmodule

`default_nettype wire

### rtl/prrts_slot_table.sv
// ----------------------------------------------------------------------------
// prrts_slot_table: task slot storage
// Status and priority live in a single-port-write memory with a registered
// read; the per-slot valid bits are flip-flops cleared by reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prrts_slot_table #(
  parameter int TASK_SLOTS = prrts_pkg::TASK_SLOTS_DEF,
  parameter int PRIO_BITS  = prrts_pkg::PRIO_BITS_DEF,
  localparam int SLOT_W    = $clog2(TASK_SLOTS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SLOT_W-1:0]      rd_addr,
  input  prrts_pkg::tbl_cmd_t    cmd,
  input  logic [SLOT_W-1:0]      wr_addr,
  input  prrts_pkg::task_status_t wr_status,
  input  logic [PRIO_BITS-1:0]   wr_prio,
  output logic                   rd_valid,
  output prrts_pkg::task_status_t rd_status,
  output logic [PRIO_BITS-1:0]   rd_prio
);
  import prrts_pkg::*;

  localparam int ENTRY_W = PRIO_BITS + 2;

  logic [TASK_SLOTS-1:0] valid;
  logic [ENTRY_W-1:0]    mem [TASK_SLOTS];
  logic [ENTRY_W-1:0]    rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.set_valid) begin
      valid[wr_addr] <= 1'b1;
    end else if (cmd.clr_valid) begin
      valid[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {wr_status, wr_prio};
    end
    rd_entry <= mem[rd_addr];
    rd_valid <= valid[rd_addr];
  end

  assign rd_status = task_status_t'(rd_entry[ENTRY_W-1 -: 2]);
  assign rd_prio   = rd_entry[PRIO_BITS-1:0];

endmodule

`default_nettype wire
